FILE: rtl/rrc_pkg.sv
// Shared types and constants for the region rectangle containment unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package rrc_pkg;

  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned ApbDataBits = 32;
  localparam int unsigned ApbAddrBits = 4;

  typedef enum logic [1:0] {
    REG_QUERY_LEFT   = 2'd0,
    REG_QUERY_TOP    = 2'd1,
    REG_QUERY_RIGHT  = 2'd2,
    REG_QUERY_BOTTOM = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic fire;
    logic has_box;
    logic last;
  } step_t;

endpackage

`default_nettype wire

FILE: rtl/rrc_cfg.sv
// APB register file holding the query rectangle edges.
// Depends on rrc_pkg.
`default_nettype none

module rrc_cfg
  import rrc_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ApbAddrBits-1:0]        paddr,
  input  logic [ApbDataBits-1:0]        pwdata,
  output logic [ApbDataBits-1:0]        prdata,
  output logic                          pready,
  output logic signed [COORD_BITS-1:0]  query_left_o,
  output logic signed [COORD_BITS-1:0]  query_top_o,
  output logic signed [COORD_BITS-1:0]  query_right_o,
  output logic signed [COORD_BITS-1:0]  query_bottom_o
);

  logic signed [COORD_BITS-1:0] left_q, top_q, right_q, bottom_q;
  logic signed [COORD_BITS-1:0] wdata;
  logic                         wr_en;
  reg_idx_e                     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wdata  = COORD_BITS'(pwdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= '0;
      bottom_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_QUERY_LEFT:   left_q   <= wdata;
        REG_QUERY_TOP:    top_q    <= wdata;
        REG_QUERY_RIGHT:  right_q  <= wdata;
        REG_QUERY_BOTTOM: bottom_q <= wdata;
        default:          left_q   <= left_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_QUERY_LEFT:   prdata = ApbDataBits'(left_q);
      REG_QUERY_TOP:    prdata = ApbDataBits'(top_q);
      REG_QUERY_RIGHT:  prdata = ApbDataBits'(right_q);
      REG_QUERY_BOTTOM: prdata = ApbDataBits'(bottom_q);
      default:          prdata = '0;
    endcase
  end

  assign query_left_o   = left_q;
  assign query_top_o    = top_q;
  assign query_right_o  = right_q;
  assign query_bottom_o = bottom_q;

endmodule

`default_nettype wire

FILE: rtl/rrc_scan.sv
// Band scan over the query rectangle: part-in/part-out flags, scan position, early stop.
// Depends on rrc_pkg.
`default_nettype none

module rrc_scan
  import rrc_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  step_t                         step_i,
  input  logic signed [COORD_BITS-1:0]  box_left_i,
  input  logic signed [COORD_BITS-1:0]  box_top_i,
  input  logic signed [COORD_BITS-1:0]  box_right_i,
  input  logic signed [COORD_BITS-1:0]  box_bottom_i,
  input  logic signed [COORD_BITS-1:0]  query_left_i,
  input  logic signed [COORD_BITS-1:0]  query_top_i,
  input  logic signed [COORD_BITS-1:0]  query_right_i,
  input  logic signed [COORD_BITS-1:0]  query_bottom_i,
  output logic                          any_seen_o,
  output logic                          inside_post_o,
  output logic                          any_post_o,
  output logic signed [COORD_BITS:0]    scan_y_post_o
);

  logic                         inside_q, outside_q, stopped_q, any_q;
  logic signed [COORD_BITS-1:0] scan_x_q;
  logic signed [COORD_BITS:0]   scan_y_q;

  logic                         ix, ox, st, done;
  logic signed [COORD_BITS-1:0] sx;
  logic signed [COORD_BITS:0]   sy;
  logic signed [COORD_BITS:0]   bt_e, bb_e, qb_e, one_e;

  assign bt_e  = (COORD_BITS+1)'(box_top_i);
  assign bb_e  = (COORD_BITS+1)'(box_bottom_i);
  assign qb_e  = (COORD_BITS+1)'(query_bottom_i);
  assign one_e = $signed((COORD_BITS+1)'(1));

  // The scan start is taken from the query at the first box of a region.
  always_comb begin
    ix   = inside_q;
    ox   = outside_q;
    st   = stopped_q;
    sx   = scan_x_q;
    sy   = scan_y_q;
    done = 1'b0;
    if (step_i.has_box) begin
      if (!any_q) begin
        sx = query_left_i;
        sy = (COORD_BITS+1)'(query_top_i);
      end
      if (!stopped_q) begin
        if (bb_e < sy) begin
          done = 1'b1;
        end
        if (!done && bt_e > sy) begin
          ox = 1'b1;
          if (ix || bt_e > qb_e) begin
            st   = 1'b1;
            done = 1'b1;
          end else begin
            sy = bt_e;
          end
        end
        if (!done && box_right_i < sx) begin
          done = 1'b1;
        end
        if (!done && box_left_i > sx) begin
          ox = 1'b1;
          if (ix) begin
            st   = 1'b1;
            done = 1'b1;
          end
        end
        if (!done && box_left_i <= query_right_i) begin
          ix = 1'b1;
          if (ox) begin
            st   = 1'b1;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (box_right_i >= query_right_i) begin
            sy = bb_e + one_e;
            if (sy > qb_e) begin
              st = 1'b1;
            end else begin
              sx = query_left_i;
            end
          end else begin
            st = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q  <= 1'b0;
      outside_q <= 1'b0;
      stopped_q <= 1'b0;
      any_q     <= 1'b0;
      scan_x_q  <= '0;
      scan_y_q  <= '0;
    end else if (step_i.fire) begin
      if (step_i.last) begin
        inside_q  <= 1'b0;
        outside_q <= 1'b0;
        stopped_q <= 1'b0;
        any_q     <= 1'b0;
        scan_x_q  <= '0;
        scan_y_q  <= '0;
      end else begin
        inside_q  <= ix;
        outside_q <= ox;
        stopped_q <= st;
        any_q     <= any_q || step_i.has_box;
        scan_x_q  <= sx;
        scan_y_q  <= sy;
      end
    end
  end

  assign any_seen_o    = any_q;
  assign inside_post_o = ix;
  assign any_post_o    = any_q || step_i.has_box;
  assign scan_y_post_o = sy;

endmodule

`default_nettype wire

FILE: rtl/rrc_bound.sv
// Bounding box of the region's boxes and the test that it holds the query.
// Depends on rrc_pkg.
`default_nettype none

module rrc_bound
  import rrc_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  step_t                         step_i,
  input  logic signed [COORD_BITS-1:0]  box_left_i,
  input  logic signed [COORD_BITS-1:0]  box_top_i,
  input  logic signed [COORD_BITS-1:0]  box_right_i,
  input  logic signed [COORD_BITS-1:0]  box_bottom_i,
  input  logic signed [COORD_BITS-1:0]  query_left_i,
  input  logic signed [COORD_BITS-1:0]  query_top_i,
  input  logic signed [COORD_BITS-1:0]  query_right_i,
  input  logic signed [COORD_BITS-1:0]  query_bottom_i,
  output logic                          holds_query_o
);

  localparam logic signed [COORD_BITS-1:0] CoordMax = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CoordMin = ~CoordMax;

  logic signed [COORD_BITS-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic signed [COORD_BITS-1:0] min_x_d, min_y_d, max_x_d, max_y_d;
  logic                         in_x, in_y;

  always_comb begin
    min_x_d = min_x_q;
    min_y_d = min_y_q;
    max_x_d = max_x_q;
    max_y_d = max_y_q;
    if (step_i.has_box) begin
      if (box_left_i < min_x_q) begin
        min_x_d = box_left_i;
      end
      if (box_top_i < min_y_q) begin
        min_y_d = box_top_i;
      end
      if (box_right_i > max_x_q) begin
        max_x_d = box_right_i;
      end
      if (box_bottom_i > max_y_q) begin
        max_y_d = box_bottom_i;
      end
    end
  end

  assign in_x = query_left_i >= min_x_d && query_left_i <= max_x_d &&
                query_right_i >= min_x_d && query_right_i <= max_x_d;
  assign in_y = query_top_i >= min_y_d && query_top_i <= max_y_d &&
                query_bottom_i >= min_y_d && query_bottom_i <= max_y_d;
  assign holds_query_o = in_x && in_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= CoordMax;
      min_y_q <= CoordMax;
      max_x_q <= CoordMin;
      max_y_q <= CoordMin;
    end else if (step_i.fire) begin
      if (step_i.last) begin
        min_x_q <= CoordMax;
        min_y_q <= CoordMax;
        max_x_q <= CoordMin;
        max_y_q <= CoordMin;
      end else begin
        min_x_q <= min_x_d;
        min_y_q <= min_y_d;
        max_x_q <= max_x_d;
        max_y_q <= max_y_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/region_rect_containment_unit.sv
// Top level: input register, band scan, bounding box and result register.
// Depends on rrc_pkg, rrc_cfg, rrc_scan and rrc_bound.
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+------------------------------------
//  box in    | box_valid_i / box_ready_o        | box_left/top/right/bottom_i, no_box_i,
//            |                                  | last_box_i
//  result    | result_valid_o / result_ready_i  | contained_o
//  config    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// One box item is taken every cycle while the input register is not stalled; its state
// update happens between the input register and the scan and bounding registers.
// An item with last_box set puts its answer into the result register when it leaves
// the input register. A full result register stalls only a last item, which then holds the
// input; other items keep flowing.
// Reset clears the query registers to zero and the region state to an empty region.
`default_nettype none

module region_rect_containment_unit
  import rrc_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ApbAddrBits-1:0]        paddr,
  input  logic [ApbDataBits-1:0]        pwdata,
  output logic [ApbDataBits-1:0]        prdata,
  output logic                          pready,
  input  logic                          box_valid_i,
  output logic                          box_ready_o,
  input  logic signed [COORD_BITS-1:0]  box_left_i,
  input  logic signed [COORD_BITS-1:0]  box_top_i,
  input  logic signed [COORD_BITS-1:0]  box_right_i,
  input  logic signed [COORD_BITS-1:0]  box_bottom_i,
  input  logic                          no_box_i,
  input  logic                          last_box_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic                          contained_o
);

  logic signed [COORD_BITS-1:0] q_left, q_top, q_right, q_bottom;
  logic signed [COORD_BITS-1:0] s1_left_q, s1_top_q, s1_right_q, s1_bottom_q;
  logic                         s1_valid_q, s1_no_box_q, s1_last_q;
  logic                         s1_go, accept;
  step_t                        step;
  logic                         any_seen, inside_post, any_post, holds_query;
  logic signed [COORD_BITS:0]   scan_y_post, ql_e, qt_e, qr_e, qb_e, one_e;
  logic                         null_query, contained_d;
  logic                         out_valid_q, contained_q;

  rrc_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .query_left_o   (q_left),
    .query_top_o    (q_top),
    .query_right_o  (q_right),
    .query_bottom_o (q_bottom)
  );

  assign s1_go       = s1_valid_q && (!s1_last_q || !out_valid_q || result_ready_i);
  assign box_ready_o = !s1_valid_q || s1_go;
  assign accept      = box_valid_i && box_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (box_ready_o) begin
      s1_valid_q <= box_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_left_q   <= box_left_i;
      s1_top_q    <= box_top_i;
      s1_right_q  <= box_right_i;
      s1_bottom_q <= box_bottom_i;
      s1_no_box_q <= no_box_i;
      s1_last_q   <= last_box_i;
    end
  end

  assign step.fire    = s1_go;
  assign step.has_box = s1_go && !s1_no_box_q;
  assign step.last    = s1_last_q;

  rrc_scan #(.COORD_BITS(COORD_BITS)) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .box_left_i     (s1_left_q),
    .box_top_i      (s1_top_q),
    .box_right_i    (s1_right_q),
    .box_bottom_i   (s1_bottom_q),
    .query_left_i   (q_left),
    .query_top_i    (q_top),
    .query_right_i  (q_right),
    .query_bottom_i (q_bottom),
    .any_seen_o     (any_seen),
    .inside_post_o  (inside_post),
    .any_post_o     (any_post),
    .scan_y_post_o  (scan_y_post)
  );

  rrc_bound #(.COORD_BITS(COORD_BITS)) u_bound (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .box_left_i     (s1_left_q),
    .box_top_i      (s1_top_q),
    .box_right_i    (s1_right_q),
    .box_bottom_i   (s1_bottom_q),
    .query_left_i   (q_left),
    .query_top_i    (q_top),
    .query_right_i  (q_right),
    .query_bottom_i (q_bottom),
    .holds_query_o  (holds_query)
  );

  assign ql_e  = (COORD_BITS+1)'(q_left);
  assign qt_e  = (COORD_BITS+1)'(q_top);
  assign qr_e  = (COORD_BITS+1)'(q_right);
  assign qb_e  = (COORD_BITS+1)'(q_bottom);
  assign one_e = $signed((COORD_BITS+1)'(1));

  assign null_query  = (qr_e == ql_e - one_e) && (qb_e == qt_e - one_e);
  assign contained_d = any_post && !null_query && holds_query && inside_post &&
                       (scan_y_post > qb_e);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      contained_q <= contained_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign contained_o    = contained_q;

  a_last_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && out_valid_q && !result_ready_i) |-> !box_ready_o)
    else $error("last item advanced while the result register was blocked");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_last_q) |=> result_valid_o)
    else $error("last item advanced without a result");

  a_region_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_last_q) |=> !any_seen)
    else $error("region state not cleared after a last item");

endmodule

`default_nettype wire
